>>> hdl/assert_macros.svh
// Assertion helpers. Expect clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lavm_pkg.sv
package lavm_pkg;

  localparam int AXIS_FRAC = 30;
  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 31;
  localparam logic [5:0] NORM_MSB = 6'd29;
  localparam logic signed [65:0] TR_HALF = 66'sh20000000;

  typedef logic [2:0][31:0] vec32_t;
  typedef logic [2:0][63:0] vec64_t;

  typedef enum logic [1:0] {
    ROW_SIDE = 2'd0,
    ROW_UP   = 2'd1,
    ROW_FWD  = 2'd2
  } row_e;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [31:0] translation;
    logic               degenerate;
    logic               last_row;
  } out_t;

  // Data riding alongside the arithmetic pipelines.
  typedef struct packed {
    vec32_t eye;
    vec32_t f;
    vec32_t s;
    logic   ok;
  } side_t;

endpackage

>>> hdl/look_at_view_matrix.sv
// Right-handed look-at view matrix. Each pose transaction (eye, target, up in
// signed Q16.16) yields three row transactions in order side, up, forward: the
// axis in Q2.30 and the translation -(axis . eye) in Q16.16, rounded half up
// and saturated; a zero-length vector anywhere gives three zero rows flagged
// degenerate. The datapath is a 222-stage pipeline (four normalizers, each a
// leading-one shift, a 32-step square root and 31-step dividers, plus two cross
// products and the translation dot products). Poses may enter on consecutive
// cycles while the pipeline has room; the output register sends one row per
// cycle while out_stall_i is low, and the whole pipeline stalls while a finished
// pose waits for the rows of the previous pose to go out.
`include "assert_macros.svh"

module look_at_view_matrix (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lavm_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lavm_pkg::out_t out_o
);

  logic               en;
  logic               in_v_q;
  lavm_pkg::vec64_t   dif_q;
  lavm_pkg::vec64_t   up_q;
  lavm_pkg::side_t    side0;
  logic signed [63:0] dif_d [3];
  logic signed [63:0] up_d  [3];

  logic               f_valid;
  lavm_pkg::vec32_t   f_axis;
  logic               f_ok;
  lavm_pkg::side_t    f_side;
  logic               u_valid;
  lavm_pkg::vec32_t   u_axis;
  logic               u_ok;
  lavm_pkg::side_t    side1;

  logic               c1_valid;
  lavm_pkg::vec64_t   c1_vec;
  lavm_pkg::side_t    c1_side;
  logic               s_valid;
  lavm_pkg::vec32_t   s_axis;
  logic               s_ok;
  lavm_pkg::side_t    s_side;
  lavm_pkg::side_t    side2;

  logic               c2_valid;
  lavm_pkg::vec64_t   c2_vec;
  lavm_pkg::side_t    c2_side;
  logic               v_valid;
  lavm_pkg::vec32_t   v_axis;
  logic               v_ok;
  lavm_pkg::side_t    v_side;

  assign in_stall_o = !en;

  always_comb begin
    dif_d[0] = in_i.eye_x - in_i.target_x;
    dif_d[1] = in_i.eye_y - in_i.target_y;
    dif_d[2] = in_i.eye_z - in_i.target_z;
    up_d[0]  = in_i.up_x;
    up_d[1]  = in_i.up_y;
    up_d[2]  = in_i.up_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (en) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dif_q[i] <= dif_d[i];
        up_q[i]  <= up_d[i];
      end
      side0.eye[0] <= in_i.eye_x;
      side0.eye[1] <= in_i.eye_y;
      side0.eye[2] <= in_i.eye_z;
      side0.f      <= '0;
      side0.s      <= '0;
      side0.ok     <= 1'b1;
    end
  end

  lavm_nrm u_nrm_f (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_v_q),
    .vec_i   (dif_q),
    .side_i  (side0),
    .valid_o (f_valid),
    .axis_o  (f_axis),
    .ok_o    (f_ok),
    .side_o  (f_side)
  );

  lavm_nrm u_nrm_u (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_v_q),
    .vec_i   (up_q),
    .side_i  (side0),
    .valid_o (u_valid),
    .axis_o  (u_axis),
    .ok_o    (u_ok),
    .side_o  ()
  );

  always_comb begin
    side1    = f_side;
    side1.f  = f_axis;
    side1.ok = f_side.ok && f_ok && u_ok;
  end

  lavm_crs u_crs_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .a_i     (u_axis),
    .b_i     (f_axis),
    .side_i  (side1),
    .valid_o (c1_valid),
    .vec_o   (c1_vec),
    .side_o  (c1_side)
  );

  lavm_nrm u_nrm_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c1_valid),
    .vec_i   (c1_vec),
    .side_i  (c1_side),
    .valid_o (s_valid),
    .axis_o  (s_axis),
    .ok_o    (s_ok),
    .side_o  (s_side)
  );

  always_comb begin
    side2    = s_side;
    side2.s  = s_axis;
    side2.ok = s_side.ok && s_ok;
  end

  lavm_crs u_crs_v (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_valid),
    .a_i     (side2.f),
    .b_i     (s_axis),
    .side_i  (side2),
    .valid_o (c2_valid),
    .vec_o   (c2_vec),
    .side_o  (c2_side)
  );

  lavm_nrm u_nrm_v (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c2_valid),
    .vec_i   (c2_vec),
    .side_i  (c2_side),
    .valid_o (v_valid),
    .axis_o  (v_axis),
    .ok_o    (v_ok),
    .side_o  (v_side)
  );

  lavm_row u_row (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v_valid),
    .side_i      (v_side),
    .v_i         (v_axis),
    .okv_i       (v_ok),
    .out_stall_i (out_stall_i),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

  `ASSERT_IMP(a_nrm_lockstep, f_valid || u_valid, f_valid && u_valid, "normalizers out of step")
  `ASSERT_IMP(a_stall_needs_row, in_stall_o, out_valid_o, "input stalled with no row pending")
  `ASSERT_NXT(a_row_order, out_valid_o && !out_stall_i && !out_o.last_row, out_valid_o && out_o.row_index == $past(out_o.row_index) + 2'd1, "row sequence broken")
  `ASSERT_IMP(a_degen_zero, out_valid_o && out_o.degenerate, out_o.axis_x == 32'sd0 && out_o.axis_y == 32'sd0 && out_o.axis_z == 32'sd0 && out_o.translation == 32'sd0, "degenerate row not zero")

endmodule

>>> hdl/lavm_nrm.sv
module lavm_nrm (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  lavm_pkg::vec64_t vec_i,
  input  lavm_pkg::side_t  side_i,
  output logic             valid_o,
  output lavm_pkg::vec32_t axis_o,
  output logic             ok_o,
  output lavm_pkg::side_t  side_o
);

  // magnitudes and max
  logic [2:0][62:0] a_m_d;
  logic [2:0]       a_neg_d;
  logic [62:0]      a_mx_d;
  logic             a_v_q;
  logic [2:0][62:0] a_m_q;
  logic [2:0]       a_neg_q;
  logic [62:0]      a_mx_q;
  lavm_pkg::side_t  a_side_q;

  always_comb begin
    a_mx_d = '0;
    for (int i = 0; i < 3; i++) begin
      a_neg_d[i] = vec_i[i][63];
      a_m_d[i]   = a_neg_d[i] ? 63'(-vec_i[i]) : vec_i[i][62:0];
      if (a_m_d[i] > a_mx_d) begin
        a_mx_d = a_m_d[i];
      end
    end
  end

  // leading-one search, per byte
  logic [63:0]     b_mx;
  logic [7:0]      b_nz_d;
  logic [7:0][2:0] b_pos_d;
  logic            b_v_q;
  logic [2:0][62:0] b_m_q;
  logic [2:0]      b_neg_q;
  logic [7:0]      b_nz_q;
  logic [7:0][2:0] b_pos_q;
  lavm_pkg::side_t b_side_q;

  assign b_mx = {1'b0, a_mx_q};

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      b_nz_d[g]  = |b_mx[8*g +: 8];
      b_pos_d[g] = '0;
      for (int k = 0; k < 8; k++) begin
        if (b_mx[8*g+k]) begin
          b_pos_d[g] = 3'(k);
        end
      end
    end
  end

  // leading-one search, byte select
  logic [5:0]       c_msb_d;
  logic             c_v_q;
  logic [2:0][62:0] c_m_q;
  logic [2:0]       c_neg_q;
  logic [5:0]       c_msb_q;
  logic             c_ok_q;
  lavm_pkg::side_t  c_side_q;

  always_comb begin
    c_msb_d = '0;
    for (int g = 0; g < 8; g++) begin
      if (b_nz_q[g]) begin
        c_msb_d = {3'(g), b_pos_q[g]};
      end
    end
  end

  // block shift into [2^29, 2^30)
  logic [5:0]       d_rsh;
  logic [5:0]       d_lsh;
  logic [2:0][29:0] d_m_d;
  logic             d_v_q;
  logic [2:0][29:0] d_m_q;
  logic [2:0]       d_neg_q;
  logic             d_ok_q;
  lavm_pkg::side_t  d_side_q;

  assign d_rsh = c_msb_q - lavm_pkg::NORM_MSB;
  assign d_lsh = lavm_pkg::NORM_MSB - c_msb_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (c_msb_q > lavm_pkg::NORM_MSB) begin
        d_m_d[i] = 30'(c_m_q[i] >> d_rsh);
      end else begin
        d_m_d[i] = 30'(c_m_q[i] << d_lsh);
      end
    end
  end

  // squares
  logic [2:0][59:0] e_sq_d;
  logic             e_v_q;
  logic [2:0][59:0] e_sq_q;
  logic [2:0][29:0] e_m_q;
  logic [2:0]       e_neg_q;
  logic             e_ok_q;
  lavm_pkg::side_t  e_side_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_sq_d[i] = d_m_q[i] * d_m_q[i];
    end
  end

  // square root, one result bit per stage
  logic             sr_v_q    [lavm_pkg::SQ_STEPS+1];
  logic [63:0]      sr_n_q    [lavm_pkg::SQ_STEPS+1];
  logic [63:0]      sr_res_q  [lavm_pkg::SQ_STEPS+1];
  logic [2:0][29:0] sr_m_q    [lavm_pkg::SQ_STEPS+1];
  logic [2:0]       sr_neg_q  [lavm_pkg::SQ_STEPS+1];
  logic             sr_ok_q   [lavm_pkg::SQ_STEPS+1];
  lavm_pkg::side_t  sr_side_q [lavm_pkg::SQ_STEPS+1];

  // division, one quotient bit per stage
  logic             dv_v_q    [lavm_pkg::DIV_STEPS+1];
  logic [2:0][60:0] dv_r_q    [lavm_pkg::DIV_STEPS+1];
  logic [2:0][30:0] dv_q_q    [lavm_pkg::DIV_STEPS+1];
  logic [30:0]      dv_d_q    [lavm_pkg::DIV_STEPS+1];
  logic [2:0]       dv_neg_q  [lavm_pkg::DIV_STEPS+1];
  logic             dv_ok_q   [lavm_pkg::DIV_STEPS+1];
  lavm_pkg::side_t  dv_side_q [lavm_pkg::DIV_STEPS+1];

  logic [30:0]      dp_len;
  logic [2:0][60:0] dp_r_d;

  assign dp_len = sr_res_q[lavm_pkg::SQ_STEPS][30:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dp_r_d[i] = 61'({sr_m_q[lavm_pkg::SQ_STEPS][i], 30'b0}) + 61'(dp_len[30:1]);
    end
  end

  // sign restore
  logic             s_v_q;
  lavm_pkg::vec32_t s_axis_d;
  lavm_pkg::vec32_t s_axis_q;
  logic             s_ok_q;
  lavm_pkg::side_t  s_side_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_neg_q[lavm_pkg::DIV_STEPS][i]) begin
        s_axis_d[i] = -{1'b0, dv_q_q[lavm_pkg::DIV_STEPS][i]};
      end else begin
        s_axis_d[i] = {1'b0, dv_q_q[lavm_pkg::DIV_STEPS][i]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q                       <= 1'b0;
      b_v_q                       <= 1'b0;
      c_v_q                       <= 1'b0;
      d_v_q                       <= 1'b0;
      e_v_q                       <= 1'b0;
      sr_v_q[0]                   <= 1'b0;
      dv_v_q[0]                   <= 1'b0;
      s_v_q                       <= 1'b0;
    end else if (en_i) begin
      a_v_q                       <= valid_i;
      b_v_q                       <= a_v_q;
      c_v_q                       <= b_v_q;
      d_v_q                       <= c_v_q;
      e_v_q                       <= d_v_q;
      sr_v_q[0]                   <= e_v_q;
      dv_v_q[0]                   <= sr_v_q[lavm_pkg::SQ_STEPS];
      s_v_q                       <= dv_v_q[lavm_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_m_q        <= a_m_d;
      a_neg_q      <= a_neg_d;
      a_mx_q       <= a_mx_d;
      a_side_q     <= side_i;

      b_m_q        <= a_m_q;
      b_neg_q      <= a_neg_q;
      b_nz_q       <= b_nz_d;
      b_pos_q      <= b_pos_d;
      b_side_q     <= a_side_q;

      c_m_q        <= b_m_q;
      c_neg_q      <= b_neg_q;
      c_msb_q      <= c_msb_d;
      c_ok_q       <= |b_nz_q;
      c_side_q     <= b_side_q;

      d_m_q        <= d_m_d;
      d_neg_q      <= c_neg_q;
      d_ok_q       <= c_ok_q;
      d_side_q     <= c_side_q;

      e_sq_q       <= e_sq_d;
      e_m_q        <= d_m_q;
      e_neg_q      <= d_neg_q;
      e_ok_q       <= d_ok_q;
      e_side_q     <= d_side_q;

      sr_n_q[0]    <= 64'(e_sq_q[0]) + 64'(e_sq_q[1]) + 64'(e_sq_q[2]);
      sr_res_q[0]  <= '0;
      sr_m_q[0]    <= e_m_q;
      sr_neg_q[0]  <= e_neg_q;
      sr_ok_q[0]   <= e_ok_q;
      sr_side_q[0] <= e_side_q;

      dv_r_q[0]    <= dp_r_d;
      dv_q_q[0]    <= '0;
      dv_d_q[0]    <= dp_len;
      dv_neg_q[0]  <= sr_neg_q[lavm_pkg::SQ_STEPS];
      dv_ok_q[0]   <= sr_ok_q[lavm_pkg::SQ_STEPS];
      dv_side_q[0] <= sr_side_q[lavm_pkg::SQ_STEPS];

      s_axis_q     <= s_axis_d;
      s_ok_q       <= dv_ok_q[lavm_pkg::DIV_STEPS];
      s_side_q     <= dv_side_q[lavm_pkg::DIV_STEPS];
    end
  end

  for (genvar j = 0; j < lavm_pkg::SQ_STEPS; j++) begin : g_sq
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*j);
    logic [63:0] trial;
    logic        take;

    assign trial = sr_res_q[j] + BIT;
    assign take  = sr_n_q[j] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sr_v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        sr_v_q[j+1] <= sr_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sr_n_q[j+1]    <= take ? sr_n_q[j] - trial : sr_n_q[j];
        sr_res_q[j+1]  <= take ? (sr_res_q[j] >> 1) + BIT : sr_res_q[j] >> 1;
        sr_m_q[j+1]    <= sr_m_q[j];
        sr_neg_q[j+1]  <= sr_neg_q[j];
        sr_ok_q[j+1]   <= sr_ok_q[j];
        sr_side_q[j+1] <= sr_side_q[j];
      end
    end
  end

  for (genvar j = 0; j < lavm_pkg::DIV_STEPS; j++) begin : g_dv
    localparam int SH = lavm_pkg::DIV_STEPS - 1 - j;
    logic [61:0]      dsh;
    logic [2:0]       take;
    logic [2:0][60:0] r_d;
    logic [2:0][30:0] q_d;

    assign dsh = 62'(dv_d_q[j]) << SH;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        take[i] = {1'b0, dv_r_q[j][i]} >= dsh;
        r_d[i]  = take[i] ? 61'({1'b0, dv_r_q[j][i]} - dsh) : dv_r_q[j][i];
        q_d[i]  = take[i] ? (dv_q_q[j][i] | (31'd1 << SH)) : dv_q_q[j][i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_r_q[j+1]    <= r_d;
        dv_q_q[j+1]    <= q_d;
        dv_d_q[j+1]    <= dv_d_q[j];
        dv_neg_q[j+1]  <= dv_neg_q[j];
        dv_ok_q[j+1]   <= dv_ok_q[j];
        dv_side_q[j+1] <= dv_side_q[j];
      end
    end
  end

  assign valid_o = s_v_q;
  assign axis_o  = s_axis_q;
  assign ok_o    = s_ok_q;
  assign side_o  = s_side_q;

endmodule

>>> hdl/lavm_crs.sv
module lavm_crs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  lavm_pkg::vec32_t a_i,
  input  lavm_pkg::vec32_t b_i,
  input  lavm_pkg::side_t  side_i,
  output logic             valid_o,
  output lavm_pkg::vec64_t vec_o,
  output lavm_pkg::side_t  side_o
);

  logic signed [63:0] p_d [6];
  logic signed [63:0] p_q [6];
  logic               p_v_q;
  lavm_pkg::side_t    p_side_q;
  logic               c_v_q;
  lavm_pkg::vec64_t   c_q;
  lavm_pkg::side_t    c_side_q;

  always_comb begin
    p_d[0] = $signed(a_i[1]) * $signed(b_i[2]);
    p_d[1] = $signed(a_i[2]) * $signed(b_i[1]);
    p_d[2] = $signed(a_i[2]) * $signed(b_i[0]);
    p_d[3] = $signed(a_i[0]) * $signed(b_i[2]);
    p_d[4] = $signed(a_i[0]) * $signed(b_i[1]);
    p_d[5] = $signed(a_i[1]) * $signed(b_i[0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else if (en_i) begin
      p_v_q <= valid_i;
      c_v_q <= p_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q      <= p_d;
      p_side_q <= side_i;
      c_q[0]   <= p_q[0] - p_q[1];
      c_q[1]   <= p_q[2] - p_q[3];
      c_q[2]   <= p_q[4] - p_q[5];
      c_side_q <= p_side_q;
    end
  end

  assign valid_o = c_v_q;
  assign vec_o   = c_q;
  assign side_o  = c_side_q;

endmodule

>>> hdl/lavm_row.sv
module lavm_row (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  lavm_pkg::side_t  side_i,
  input  lavm_pkg::vec32_t v_i,
  input  logic             okv_i,
  input  logic             out_stall_i,
  output logic             en_o,
  output logic             out_valid_o,
  output lavm_pkg::out_t   out_o
);

  lavm_pkg::vec32_t   ax       [3];
  logic signed [63:0] t1_pr_d  [3][3];
  logic               t1_v_q;
  logic signed [63:0] t1_pr_q  [3][3];
  lavm_pkg::vec32_t   t1_ax_q  [3];
  logic               t1_ok_q;
  logic signed [65:0] t2_sum_d [3];
  logic               t2_v_q;
  logic signed [65:0] t2_sum_q [3];
  lavm_pkg::vec32_t   t2_ax_q  [3];
  logic               t2_ok_q;
  logic signed [65:0] t3_acc   [3];
  logic signed [35:0] t3_flr   [3];
  logic [31:0]        t3_tr_d  [3];
  lavm_pkg::vec32_t   t3_ax_d  [3];
  logic               t3_v_q;
  logic [31:0]        t3_tr_q  [3];
  lavm_pkg::vec32_t   t3_ax_q  [3];
  logic               t3_deg_q;

  logic               tv_q;
  lavm_pkg::row_e     row_q;
  lavm_pkg::vec32_t   tl_ax_q  [3];
  logic [31:0]        tl_tr_q  [3];
  logic               tl_deg_q;
  logic               done;
  logic               load_ok;

  assign ax[0] = side_i.s;
  assign ax[1] = v_i;
  assign ax[2] = side_i.f;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        t1_pr_d[k][i] = $signed(ax[k][i]) * $signed(side_i.eye[i]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t2_sum_d[k] = t1_pr_q[k][0] + t1_pr_q[k][1] + t1_pr_q[k][2];
    end
  end

  // -(sum), round half up by 2^30, saturate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t3_acc[k] = lavm_pkg::TR_HALF - t2_sum_q[k];
      t3_flr[k] = 36'(t3_acc[k] >>> lavm_pkg::AXIS_FRAC);
      if (t3_flr[k][35:31] != {5{t3_flr[k][35]}}) begin
        t3_tr_d[k] = t3_flr[k][35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        t3_tr_d[k] = t3_flr[k][31:0];
      end
      t3_ax_d[k] = t2_ax_q[k];
      if (!t2_ok_q) begin
        t3_tr_d[k] = '0;
        t3_ax_d[k] = '0;
      end
    end
  end

  assign done    = tv_q && !out_stall_i && (row_q == lavm_pkg::ROW_FWD);
  assign load_ok = !tv_q || done;
  assign en_o    = !t3_v_q || load_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_v_q <= 1'b0;
      t2_v_q <= 1'b0;
      t3_v_q <= 1'b0;
      tv_q   <= 1'b0;
      row_q  <= lavm_pkg::ROW_SIDE;
    end else begin
      if (en_o) begin
        t1_v_q <= valid_i;
        t2_v_q <= t1_v_q;
        t3_v_q <= t2_v_q;
      end
      if (en_o && t3_v_q) begin
        tv_q  <= 1'b1;
        row_q <= lavm_pkg::ROW_SIDE;
      end else if (done) begin
        tv_q  <= 1'b0;
      end else if (tv_q && !out_stall_i) begin
        case (row_q)
          lavm_pkg::ROW_SIDE: row_q <= lavm_pkg::ROW_UP;
          lavm_pkg::ROW_UP:   row_q <= lavm_pkg::ROW_FWD;
          default:            row_q <= lavm_pkg::ROW_SIDE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      t1_pr_q  <= t1_pr_d;
      t1_ax_q  <= ax;
      t1_ok_q  <= side_i.ok && okv_i;
      t2_sum_q <= t2_sum_d;
      t2_ax_q  <= t1_ax_q;
      t2_ok_q  <= t1_ok_q;
      t3_tr_q  <= t3_tr_d;
      t3_ax_q  <= t3_ax_d;
      t3_deg_q <= !t2_ok_q;
    end
    if (en_o && t3_v_q) begin
      tl_ax_q  <= t3_ax_q;
      tl_tr_q  <= t3_tr_q;
      tl_deg_q <= t3_deg_q;
    end
  end

  assign out_valid_o       = tv_q;
  assign out_o.row_index   = row_q;
  assign out_o.axis_x      = tl_ax_q[row_q][0];
  assign out_o.axis_y      = tl_ax_q[row_q][1];
  assign out_o.axis_z      = tl_ax_q[row_q][2];
  assign out_o.translation = tl_tr_q[row_q];
  assign out_o.degenerate  = tl_deg_q;
  assign out_o.last_row    = (row_q == lavm_pkg::ROW_FWD);

endmodule
